[rtl/linear_body_integrator_macros.svh]
// Assertion macros for the linear body integrator RTL.
// Included by linear_body_integrator for its checks; no other dependencies.
`ifndef LINEAR_BODY_INTEGRATOR_MACROS_SVH
`define LINEAR_BODY_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled in reset
`define LBI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define LBI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lbi_pkg.sv]
// Shared types, constants and helpers of the linear body integrator.
// No dependencies; imported by lbi_root_div, linear_body_integrator, lbi_checker and testbench.
package lbi_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_WIDTH = 2 * WORD_WIDTH;
  localparam int FM_WIDTH   = PROD_WIDTH - FRAC_BITS + 1;
  localparam int SUM_WIDTH  = FM_WIDTH + 1;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_STEP     = 2'd0,
    CMD_LOAD_POS = 2'd1,
    CMD_LOAD_VEL = 2'd2,
    CMD_NOP      = 2'd3
  } lbi_cmd_t;

  typedef enum logic [2:0] {
    REG_ACCEL_X   = 3'd0,
    REG_ACCEL_Y   = 3'd1,
    REG_ACCEL_Z   = 3'd2,
    REG_INV_MASS  = 3'd3,
    REG_STEP_TIME = 3'd4,
    REG_MAX_SPEED = 3'd5,
    REG_DAMPING   = 3'd6,
    REG_ZERO_THR  = 3'd7
  } lbi_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ1, S_ROOT, S_CLAMP, S_CLAMPW, S_ACC, S_POS,
    S_VEL, S_SQ2, S_DAMP, S_ZERO, S_DONE
  } lbi_state_t;

  typedef enum logic {
    MODE_SQRT = 1'b0,
    MODE_DIV  = 1'b1
  } lbi_mode_t;

  // Control into and status out of the shared shift-subtract unit
  typedef struct packed {
    logic      start;
    lbi_mode_t mode;
  } lbi_unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lbi_unit_sts_t;

  function automatic logic [WORD_WIDTH-1:0] mag(input word_t v);
    return v[WORD_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic word_t sat_word(input logic signed [SUM_WIDTH-1:0] v);
    logic signed [SUM_WIDTH-1:0] hi;
    logic signed [SUM_WIDTH-1:0] lo;
    hi = SUM_WIDTH'({1'b0, {(WORD_WIDTH-1){1'b1}}});
    lo = -hi - 1'b1;
    if (v > hi) return word_t'(hi[WORD_WIDTH-1:0]);
    if (v < lo) return word_t'(lo[WORD_WIDTH-1:0]);
    return word_t'(v[WORD_WIDTH-1:0]);
  endfunction

endpackage

[rtl/linear_body_integrator.sv]
// Linear body integrator: one body's position and velocity advanced by
// explicit Euler steps in signed Q16.16 fixed point.
//
// Input channel s_axis: tuser carries the command (step with force, load
// position, load velocity, no-op), tdata carries the vector x, y, z.
// Output channel m_axis: every accepted item yields one transfer with the
// position and velocity held after it.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// the user writes only while the block is idle; the block does not enforce it.
// Sequence: a load or no-op passes S_DONE on its way to the output register. A
// step passes S_SQ1, S_ROOT, S_CLAMP and S_CLAMPW when the speed is clamped,
// S_ACC, S_POS, S_VEL, S_SQ2, S_DAMP when damping applies, and S_ZERO: the
// square root and each of the three divisions hold the shared shift-subtract
// unit, and every multiply runs on one shared 32x32 multiplier.
// One item is in work at a time; s_axis_tready is high when the sequencer is
// idle, from the cycle after the result is registered, also while that
// result waits in the output register. When m_axis stalls, the next result
// waits before the output register and the sequencer holds.
// Reset clears the state, the registers to their defaults and the output valid.
module linear_body_integrator
  import lbi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // vec_x[31:0], vec_y[63:32], vec_z[95:64]
  input  logic [1:0]   s_axis_tuser,   // cmd[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  logic         cfg_we,
  input  logic [3:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  `include "linear_body_integrator_macros.svh"

  // Configuration registers
  word_t       accel_c [3];
  logic [30:0] inv_mass;
  logic [30:0] step_time;
  logic [30:0] max_speed;
  logic [16:0] damping;
  logic [15:0] zero_thr;

  // Body state and working registers
  word_t       pos [3];
  word_t       vel [3];
  word_t       acc [3];
  word_t       vec [3];
  logic [PROD_WIDTH-1:0] prod;
  logic [PROD_WIDTH-1:0] sumsq;
  logic [1:0]  idx;
  logic        half;
  lbi_state_t  state;
  lbi_state_t  state_next;

  logic        in_xfer;
  logic        out_free;
  logic [WORD_WIDTH-1:0] mul_a;
  logic [WORD_WIDTH-1:0] mul_b;
  logic        mul_neg;
  logic signed [FM_WIDTH-1:0] fm;
  logic [PROD_WIDTH-1:0] sum_next;

  lbi_unit_ctl_t         unit_ctl;
  lbi_unit_sts_t         unit_sts;
  logic [PROD_WIDTH-1:0] unit_op;
  logic [WORD_WIDTH-1:0] unit_res;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign sum_next = sumsq + prod;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_c[0] <= '0;
      accel_c[1] <= '0;
      accel_c[2] <= '0;
      inv_mass   <= 31'd65536;
      step_time  <= 31'd1092;
      max_speed  <= 31'd6553600;
      damping    <= 17'd65536;
      zero_thr   <= 16'd1;
    end else if (cfg_we && !cfg_index[3]) begin
      unique case (lbi_reg_t'(cfg_index[2:0]))
        REG_ACCEL_X:   accel_c[0] <= cfg_data;
        REG_ACCEL_Y:   accel_c[1] <= cfg_data;
        REG_ACCEL_Z:   accel_c[2] <= cfg_data;
        REG_INV_MASS:  inv_mass   <= cfg_data[30:0];
        REG_STEP_TIME: step_time  <= cfg_data[30:0];
        REG_MAX_SPEED: max_speed  <= cfg_data[30:0];
        REG_DAMPING:   damping    <= cfg_data[16:0];
        REG_ZERO_THR:  zero_thr   <= cfg_data[15:0];
      endcase
    end
  end

  // Select multiplier operands for the current phase
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_neg = 1'b0;
    unique case (state)
      S_SQ1, S_SQ2: begin
        mul_a = mag(vel[idx]);
        mul_b = mag(vel[idx]);
      end
      S_CLAMP: begin
        mul_a = mag(vel[idx]);
        mul_b = {1'b0, max_speed};
      end
      S_ACC: begin
        mul_a = mag(vec[idx]);
        mul_b = {1'b0, inv_mass};
        mul_neg = vec[idx][WORD_WIDTH-1];
      end
      S_POS: begin
        mul_a = mag(vel[idx]);
        mul_b = {1'b0, step_time};
        mul_neg = vel[idx][WORD_WIDTH-1];
      end
      S_VEL: begin
        mul_a = mag(acc[idx]);
        mul_b = {1'b0, step_time};
        mul_neg = acc[idx][WORD_WIDTH-1];
      end
      S_DAMP: begin
        mul_a = mag(vel[idx]);
        mul_b = {15'd0, damping};
        mul_neg = vel[idx][WORD_WIDTH-1];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Shift the registered product down and restore the sign
  always_comb begin
    fm = $signed({1'b0, prod[PROD_WIDTH-1:FRAC_BITS]});
    if (mul_neg) fm = -fm;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:
        if (in_xfer) begin
          state_next = (lbi_cmd_t'(s_axis_tuser) == CMD_STEP) ? S_SQ1 : S_DONE;
        end
      S_SQ1:    if (half && idx == 2'd2) state_next = S_ROOT;
      S_ROOT:
        if (unit_sts.done) begin
          state_next = (unit_res > {1'b0, max_speed}) ? S_CLAMP : S_ACC;
        end
      S_CLAMP:  if (half) state_next = S_CLAMPW;
      S_CLAMPW:
        if (unit_sts.done) begin
          state_next = (idx == 2'd2) ? S_ACC : S_CLAMP;
        end
      S_ACC:    if (half && idx == 2'd2) state_next = S_POS;
      S_POS:    if (half && idx == 2'd2) state_next = S_VEL;
      S_VEL:    if (half && idx == 2'd2) state_next = S_SQ2;
      S_SQ2:
        if (half && idx == 2'd2) begin
          state_next = (sum_next > (PROD_WIDTH'(1) << (2 * FRAC_BITS))) ? S_DAMP : S_ZERO;
        end
      S_DAMP:   if (half && idx == 2'd2) state_next = S_ZERO;
      S_ZERO:   state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Handshake and unit control
  always_comb begin
    s_axis_tready  = (state == S_IDLE);
    unit_ctl.start = 1'b0;
    unit_ctl.mode  = MODE_SQRT;
    unit_op        = sum_next;
    if (state == S_SQ1 && half && idx == 2'd2) begin
      unit_ctl.start = 1'b1;
    end else if (state == S_CLAMP && half) begin
      unit_ctl.start = 1'b1;
      unit_ctl.mode  = MODE_DIV;
      unit_op        = prod;
    end
  end

  lbi_root_div u_root_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     (unit_ctl),
    .operand (unit_op),
    .divisor (sumsq[WORD_WIDTH-1:0]),
    .sts     (unit_sts),
    .result  (unit_res)
  );

  // Sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      half  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      state <= state_next;
      prod  <= mul_a * mul_b;
      half  <= (state_next != state) ? 1'b0 : ~half;

      // Advance the element index; hold it while a division runs
      if (state == S_CLAMPW && unit_sts.done && idx != 2'd2) begin
        idx <= idx + 1'b1;
      end else if (state == S_CLAMP || (state == S_CLAMPW && !unit_sts.done)) begin
        idx <= idx;
      end else if (state_next != state) begin
        idx <= '0;
      end else if (half) begin
        idx <= idx + 1'b1;
      end

      unique case (state)
        S_IDLE:
          if (in_xfer) begin
            sumsq <= '0;
            for (int i = 0; i < 3; i++) begin
              vec[i] <= s_axis_tdata[i*WORD_WIDTH +: WORD_WIDTH];
            end
            if (lbi_cmd_t'(s_axis_tuser) == CMD_LOAD_POS) begin
              for (int i = 0; i < 3; i++) pos[i] <= s_axis_tdata[i*WORD_WIDTH +: WORD_WIDTH];
            end else if (lbi_cmd_t'(s_axis_tuser) == CMD_LOAD_VEL) begin
              for (int i = 0; i < 3; i++) vel[i] <= s_axis_tdata[i*WORD_WIDTH +: WORD_WIDTH];
            end
          end
        S_SQ1, S_SQ2:
          if (half) sumsq <= (idx == 2'd2 && state == S_SQ1) ? '0 : sum_next;
        S_ROOT:
          // Keep the speed as the divisor for the clamp
          if (unit_sts.done) sumsq <= PROD_WIDTH'(unit_res);
        S_CLAMPW:
          if (unit_sts.done) begin
            vel[idx] <= vel[idx][WORD_WIDTH-1] ? -word_t'(unit_res) : word_t'(unit_res);
          end
        S_ACC:
          if (half) acc[idx] <= sat_word(SUM_WIDTH'(accel_c[idx]) + SUM_WIDTH'(fm));
        S_POS:
          if (half) pos[idx] <= sat_word(SUM_WIDTH'(pos[idx]) + SUM_WIDTH'(fm));
        S_VEL:
          if (half) begin
            vel[idx] <= sat_word(SUM_WIDTH'(vel[idx]) + SUM_WIDTH'(fm));
            if (idx == 2'd2) sumsq <= '0;
          end
        S_DAMP:
          if (half) vel[idx] <= sat_word(SUM_WIDTH'(fm));
        S_ZERO:
          for (int i = 0; i < 3; i++) begin
            if (mag(vel[i]) < {16'd0, zero_thr}) vel[i] <= '0;
          end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  `LBI_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_xfer, state != S_IDLE, "accept stayed idle")
  `LBI_ASSERT_NOW(a_unit_done_waited, clk, rst, unit_sts.done, state == S_ROOT || state == S_CLAMPW, "unit result unused")
  `LBI_ASSERT_NEXT(a_done_holds, clk, rst, state == S_DONE && m_axis_tvalid && !m_axis_tready, state == S_DONE, "result dropped on stall")
  `LBI_ASSERT_NOW(a_unit_idle_start, clk, rst, unit_ctl.start, !unit_sts.busy, "unit restarted while busy")

endmodule

[rtl/lbi_root_div.sv]
// Shared iterative shift-subtract unit: 64-bit integer square root or
// 64-by-32 division with a 32-bit quotient, one result bit per cycle.
// Depends on lbi_pkg.
module lbi_root_div
  import lbi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  lbi_unit_ctl_t         ctl,
  input  logic [PROD_WIDTH-1:0] operand,
  input  logic [WORD_WIDTH-1:0] divisor,
  output lbi_unit_sts_t         sts,
  output logic [WORD_WIDTH-1:0] result
);

  localparam int REM_WIDTH = WORD_WIDTH + 3;
  localparam int CNT_WIDTH = $clog2(WORD_WIDTH + 1);

  logic [REM_WIDTH-1:0]  rem;
  logic [PROD_WIDTH-1:0] src;
  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] dvs;
  lbi_mode_t             mode;
  logic [CNT_WIDTH-1:0]  cnt;
  logic                  busy;
  logic                  done;

  logic [REM_WIDTH-1:0]  rem_sh;
  logic [REM_WIDTH-1:0]  trial;
  logic                  ge;

  // Form the shifted remainder and the trial subtrahend
  always_comb begin
    if (mode == MODE_SQRT) begin
      rem_sh = {rem[REM_WIDTH-3:0], src[PROD_WIDTH-1 -: 2]};
      trial  = {1'b0, acc, 2'b01};
    end else begin
      rem_sh = {rem[REM_WIDTH-2:0], src[PROD_WIDTH-1]};
      trial  = {3'b000, dvs};
    end
    ge = (rem_sh >= trial);
  end

  // Iterate one result bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        mode <= ctl.mode;
        dvs  <= divisor;
        acc  <= '0;
        if (ctl.mode == MODE_SQRT) begin
          rem <= '0;
          src <= operand;
        end else begin
          rem <= {3'b000, operand[PROD_WIDTH-1 -: WORD_WIDTH]};
          src <= {operand[WORD_WIDTH-1:0], {WORD_WIDTH{1'b0}}};
        end
      end else if (busy) begin
        rem <= ge ? (rem_sh - trial) : rem_sh;
        acc <= {acc[WORD_WIDTH-2:0], ge};
        src <= (mode == MODE_SQRT) ? (src << 2) : (src << 1);
        cnt <= cnt + 1'b1;
        if (cnt == CNT_WIDTH'(WORD_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign result   = acc;

endmodule

[tb/sv/lbi_checker.sv]
// Checker for the linear body integrator: watches both stream channels and
// the register port, predicts each result and compares. Depends on lbi_pkg.
`timescale 1ns / 100ps

module lbi_checker
  import lbi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [191:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           error_count,
  output int           pending_count
);

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  longint accel_cfg [3];
  longint inv_mass, dt, vmax, damp, zthr;
  longint body_pos [3];
  longint body_vel [3];
  logic [191:0] state_queue [$];

  function automatic longint clip(input longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint absval(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Magnitudes fit in 32 bits and factors in 31, so the product fits 63 bits
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = (absval(a) * b) >>> FRAC_BITS;
    return a < 0 ? -p : p;
  endfunction

  // Three squares of up to 2^62 each need the full unsigned 64-bit range
  function automatic longint unsigned speed_sq();
    longint unsigned s;
    s = 0;
    for (int i = 0; i < 3; i++) s += absval(body_vel[i]) * absval(body_vel[i]);
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= x) r += 64'd1 << b;
    return r;
  endfunction

  // Advance the body by one item and return the packed state
  function automatic logic [191:0] advance_body(input lbi_cmd_t cmd, input logic [95:0] d);
    longint vec [3];
    longint acc [3];
    longint unsigned spd;
    logic [191:0] r;
    for (int i = 0; i < 3; i++) vec[i] = longint'($signed(d[32*i +: 32]));
    case (cmd)
      CMD_LOAD_POS: for (int i = 0; i < 3; i++) body_pos[i] = vec[i];
      CMD_LOAD_VEL: for (int i = 0; i < 3; i++) body_vel[i] = vec[i];
      CMD_STEP: begin
        spd = int_sqrt(speed_sq());
        if (spd > vmax)
          for (int i = 0; i < 3; i++) begin
            acc[i] = (absval(body_vel[i]) * vmax) / spd;
            body_vel[i] = body_vel[i] < 0 ? -acc[i] : acc[i];
          end
        for (int i = 0; i < 3; i++) acc[i] = clip(accel_cfg[i] + qmul(vec[i], inv_mass));
        for (int i = 0; i < 3; i++) body_pos[i] = clip(body_pos[i] + qmul(body_vel[i], dt));
        for (int i = 0; i < 3; i++) body_vel[i] = clip(body_vel[i] + qmul(acc[i], dt));
        if (speed_sq() > (64'd1 << (2 * FRAC_BITS)))
          for (int i = 0; i < 3; i++) body_vel[i] = clip(qmul(body_vel[i], damp));
        for (int i = 0; i < 3; i++)
          if (absval(body_vel[i]) < zthr) body_vel[i] = 0;
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      r[32*i +: 32] = body_pos[i][31:0];
      r[96 + 32*i +: 32] = body_vel[i][31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Track register writes and input transfers, and check output transfers
  always @(posedge clk) begin
    if (rst) begin
      accel_cfg = '{0, 0, 0};
      inv_mass = 65536; dt = 1092; vmax = 6553600; damp = 65536; zthr = 1;
      body_pos = '{0, 0, 0};
      body_vel = '{0, 0, 0};
      state_queue.delete();
      error_count = 0;
    end else begin
      if (cfg_we)
        case (cfg_index)
          REG_ACCEL_X:   accel_cfg[0] = longint'($signed(cfg_data));
          REG_ACCEL_Y:   accel_cfg[1] = longint'($signed(cfg_data));
          REG_ACCEL_Z:   accel_cfg[2] = longint'($signed(cfg_data));
          REG_INV_MASS:  inv_mass = cfg_data[30:0];
          REG_STEP_TIME: dt = cfg_data[30:0];
          REG_MAX_SPEED: vmax = cfg_data[30:0];
          REG_DAMPING:   damp = cfg_data[16:0];
          REG_ZERO_THR:  zthr = cfg_data[15:0];
          default: ;
        endcase
      if (m_axis_tvalid && m_axis_tready) begin
        if (state_queue.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          logic [191:0] want;
          want = state_queue.pop_front();
          for (int f = 0; f < 6; f++)
            if (m_axis_tdata[32*f +: 32] !== want[32*f +: 32])
              report_mismatch(f < 3 ? $sformatf("pos[%0d]", f) : $sformatf("vel[%0d]", f - 3),
                              $signed(m_axis_tdata[32*f +: 32]), $signed(want[32*f +: 32]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        state_queue.push_back(advance_body(lbi_cmd_t'(s_axis_tuser), s_axis_tdata));
    end
    pending_count = state_queue.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the linear body integrator testbench: clock, reset, stimulus and
// verdict. Depends on lbi_pkg, linear_body_integrator and lbi_checker.
`timescale 1ns / 100ps

module testbench;
  import lbi_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [3:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           error_count;
  int           pending_count;
  int           burst_left = 0;

  always #1 clk = ~clk;

  linear_body_integrator i_dut (.*);

  lbi_checker i_checker (.*);

  // Receiver stall pattern: phases of always-ready and random stalls
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) phase = $urandom_range(0, 2);
      case (phase)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= $urandom_range(0, 3) != 0;
        default: m_axis_tready <= $urandom_range(0, 4) == 0;
      endcase
    end
  end

  task automatic write_reg(input lbi_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= {1'b0, idx};
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain outstanding results before touching registers
  task automatic wait_idle();
    while (pending_count != 0 || s_axis_tvalid) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Present one item after an optional burst gap, hold until transferred;
  // tvalid is updated at once so back-to-back calls never schedule it twice
  task automatic send_item(input lbi_cmd_t cmd, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [31:0] rand_word(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 400000)) - 200000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  task automatic random_config(input int flavor);
    write_reg(REG_ACCEL_X, flavor == 0 ? 32'h8000_0000 : rand_word($urandom_range(1, 3)));
    write_reg(REG_ACCEL_Y, flavor == 0 ? 32'h7FFF_FFFF : rand_word($urandom_range(1, 3)));
    write_reg(REG_ACCEL_Z, rand_word(flavor == 0 ? 0 : 1));
    write_reg(REG_INV_MASS, flavor == 0 ? 32'h7FFF_FFFF : $urandom_range(0, 200000));
    write_reg(REG_STEP_TIME, flavor == 0 ? 32'h7FFF_FFFF :
              flavor == 1 ? 32'd0 : $urandom_range(0, 70000));
    write_reg(REG_MAX_SPEED, flavor == 1 ? 32'd0 :
              flavor == 0 ? 32'h7FFF_FFFF : $urandom_range(1, 3000000));
    write_reg(REG_DAMPING, flavor == 1 ? 32'd0 : $urandom_range(0, 65536));
    write_reg(REG_ZERO_THR, flavor == 0 ? 32'hFFFF : $urandom_range(0, 3000));
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: loads at the extremes, steps, clamp, damping, no-op command
    send_item(CMD_LOAD_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_item(CMD_LOAD_VEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_item(CMD_STEP, 32'd0, 32'd0, 32'd0);
    send_item(CMD_LOAD_VEL, 32'h0000_8000, 32'h0000_4000, 32'd1);
    send_item(CMD_STEP, 32'd0, 32'd0, 32'd0);
    send_item(CMD_LOAD_VEL, 32'd1, 32'hFFFF_FFFF, 32'd0);
    send_item(CMD_STEP, 32'd0, 32'd0, 32'd0);
    send_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_LOAD_VEL, 32'h0100_0000, 32'h0100_0000, 32'h8000_0000);
    send_item(CMD_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
    wait_idle();
    write_reg(REG_ACCEL_X, 32'd0);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= 4'd12; cfg_data <= 32'hFFFF_FFFF;
    @(negedge clk);
    cfg_we <= 1'b0;
    random_config(0);
    send_item(CMD_LOAD_VEL, 32'h0200_0000, 32'hFE00_0000, 32'h0000_0100);
    send_item(CMD_STEP, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_STEP, 32'd0, 32'd0, 32'd0);
    wait_idle();
    random_config(1);
    send_item(CMD_STEP, 32'h7FFF_FFFF, 32'd5, 32'd0);
    send_item(CMD_LOAD_VEL, 32'h0003_0000, 32'd2, 32'hFFFF_0000);
    send_item(CMD_STEP, 32'd0, 32'd0, 32'd0);

    // Random phases: mostly steps with occasional loads and no-ops, new settings each phase
    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      if (ph == 0) begin
        write_reg(REG_INV_MASS, 32'd65536); write_reg(REG_STEP_TIME, 32'd1092);
        write_reg(REG_MAX_SPEED, 32'd6553600); write_reg(REG_DAMPING, 32'd65536);
      end else begin
        random_config(ph == 6 ? 0 : ph == 9 ? 1 : 2);
      end
      for (int n = 0; n < 160; n++) begin
        k = $urandom_range(0, 19);
        if (k < 13)
          send_item(CMD_STEP, rand_word($urandom_range(0, 3)),
                    rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)));
        else
          send_item(lbi_cmd_t'($urandom_range(1, 3)), rand_word($urandom_range(0, 3)),
                    rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)));
      end
    end

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
